// ===== rtl/bidst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounded id set table.
// No dependencies; imported by bounded_id_set_table_core and the testbench.
package bidst_pkg;

    localparam int MODE_W  = 2;
    localparam int ID_W    = 32;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    localparam logic [ID_W-1:0] EMPTY_ID = 32'hFFFF_FFFF;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic signed [ID_W-1:0] item_id;
        logic [IDX_W-1:0]       slot_index;
    } t_req;

    typedef struct packed {
        logic                   status;
        logic [COUNT_W-1:0]     entry_count;
        logic signed [ID_W-1:0] read_value;
    } t_rsp;

endpackage

// ===== rtl/bounded_id_set_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the bounded id set table: control sequencer around one entry RAM.
// Depends on bidst_pkg and bidst_ram.
//
// Usage:
//   Request channel: drive i_req (mode, item_id, slot_index) and raise start.
//   The beat is taken at a rising edge with start high and busy low. busy then
//   stays high until the result is shown.
//   Result channel: o_done is high for exactly one cycle with o_rsp valid;
//   the receiver cannot stall, so the beat is taken at the end of that cycle.
//   busy drops in that same cycle, so the next request may be taken there.
// Sequence from accept to o_done:
//   add / query         : scan the stored entries in order until a hit or the end
//   add miss            : the id is appended at the end of the list
//   delete hit          : scan, then shift of later entries down one slot
//   delete miss         : a scan of every stored entry
//   read                : a RAM read of slot_index, then the result
//   add when full, query of the empty marker: straight to the error result
//   The RAM scan and shift handle one entry per cycle.
// Reset: the count clears at once; no RAM clearing pass is needed, since only
// slots below the count are ever used and others report the empty marker.
module bounded_id_set_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  bidst_pkg::t_req  i_req,
    output logic             busy,
    output logic             o_done,
    output bidst_pkg::t_rsp  o_rsp
);

    import bidst_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IDXEW = (CW > IDX_W) ? CW : IDX_W;
    localparam int CNTEW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_RDOUT,
        S_FAIL
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_ptr;      // next slot to issue a RAM read for
    logic                r_cmp_vld;  // RAM data this cycle belongs to r_cmp_addr
    logic [CW-1:0]       r_cmp_addr;
    logic [MODE_W-1:0]   r_mode;
    logic [ID_W-1:0]     r_id;
    logic [IDX_W-1:0]    r_idx;
    logic                r_done;
    t_rsp                r_rsp;

    logic [ID_W-1:0]     ram_rdata;
    logic [AW-1:0]       ram_raddr;
    logic [AW-1:0]       ram_waddr;
    logic [ID_W-1:0]     ram_wdata;
    logic                ram_we;

    logic                scan_hit;
    logic                scan_end;
    logic [CW-1:0]       cmp_prev;
    logic [IDXEW-1:0]    idx_ext;
    logic                idx_in_range;
    logic [CW-1:0]       count_inc;
    logic [CW-1:0]       count_dec;
    logic [CNTEW-1:0]    cnt_cur_ext;
    logic [CNTEW-1:0]    cnt_inc_ext;
    logic [CNTEW-1:0]    cnt_dec_ext;

    // Scan bookkeeping: a hit needs valid RAM data; the scan ends when nothing
    // is left to issue and the last compare missed.
    assign scan_hit     = r_cmp_vld && (ram_rdata == r_id);
    assign scan_end     = !scan_hit && (r_ptr >= r_count);
    assign cmp_prev     = r_cmp_addr - CW'(1);
    assign idx_ext      = IDXEW'(r_idx);
    assign idx_in_range = (idx_ext < IDXEW'(r_count));
    assign count_inc    = r_count + CW'(1);
    assign count_dec    = r_count - CW'(1);
    assign cnt_cur_ext  = CNTEW'(r_count);
    assign cnt_inc_ext  = CNTEW'(count_inc);
    assign cnt_dec_ext  = CNTEW'(count_dec);

    // RAM port control
    always_comb begin
        ram_raddr = r_ptr[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = r_id;
        case (r_state)
            S_SCAN: begin
                // append on an add miss; the full case never reaches the scan
                ram_we = scan_end && (r_mode == MODE_ADD);
            end
            S_SHIFT: begin
                // move the entry that just came out of the RAM down one slot
                ram_we    = r_cmp_vld;
                ram_waddr = cmp_prev[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_READ: begin
                ram_raddr = idx_ext[AW-1:0];
            end
            default: begin
                ram_raddr = r_ptr[AW-1:0];
            end
        endcase
    end

    bidst_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: state, count and the registered result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (start) begin
                        r_mode    <= i_req.mode;
                        r_id      <= i_req.item_id;
                        r_idx     <= i_req.slot_index;
                        r_ptr     <= '0;
                        r_cmp_vld <= 1'b0;
                        case (i_req.mode)
                            MODE_ADD: begin
                                r_state <= (r_count >= CW'(CAPACITY)) ? S_FAIL : S_SCAN;
                            end
                            MODE_DEL: begin
                                r_state <= S_SCAN;
                            end
                            MODE_QUERY: begin
                                r_state <= (i_req.item_id == EMPTY_ID) ? S_FAIL : S_SCAN;
                            end
                            MODE_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_FAIL;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_cmp_addr       <= r_ptr;
                    r_rsp.read_value <= EMPTY_ID;
                    r_done           <= (scan_hit && (r_mode != MODE_DEL)) || scan_end;
                    if (scan_hit && (r_mode == MODE_DEL)) begin
                        // restart reads just past the match for the shift
                        r_ptr     <= r_cmp_addr + CW'(1);
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_SHIFT;
                    end else begin
                        // advance the read pointer while slots remain
                        r_cmp_vld <= (r_ptr < r_count);
                        if (r_ptr < r_count) begin
                            r_ptr <= r_ptr + CW'(1);
                        end
                        if (scan_hit) begin
                            r_rsp.status      <= (r_mode == MODE_ADD) ? STATUS_ERR
                                                                      : STATUS_OK;
                            r_rsp.entry_count <= cnt_cur_ext[COUNT_W-1:0];
                            r_state           <= S_IDLE;
                        end else if (scan_end) begin
                            if (r_mode == MODE_ADD) begin
                                r_count           <= count_inc;
                                r_rsp.entry_count <= cnt_inc_ext[COUNT_W-1:0];
                                r_rsp.status      <= STATUS_OK;
                            end else begin
                                r_rsp.entry_count <= cnt_cur_ext[COUNT_W-1:0];
                                r_rsp.status      <= STATUS_ERR;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHIFT: begin
                    r_cmp_vld  <= (r_ptr < r_count);
                    r_cmp_addr <= r_ptr;
                    if (r_ptr < r_count) begin
                        r_ptr  <= r_ptr + CW'(1);
                        r_done <= 1'b0;
                    end else begin
                        // last move is written this cycle; drop the count
                        r_count            <= count_dec;
                        r_rsp.status       <= STATUS_OK;
                        r_rsp.entry_count  <= cnt_dec_ext[COUNT_W-1:0];
                        r_rsp.read_value   <= EMPTY_ID;
                        r_done             <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_done  <= 1'b0;
                    r_state <= S_RDOUT;
                end
                S_RDOUT: begin
                    r_rsp.status      <= idx_in_range ? STATUS_OK : STATUS_ERR;
                    r_rsp.entry_count <= cnt_cur_ext[COUNT_W-1:0];
                    r_rsp.read_value  <= idx_in_range ? ram_rdata : EMPTY_ID;
                    r_done            <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_FAIL: begin
                    r_rsp.status      <= STATUS_ERR;
                    r_rsp.entry_count <= cnt_cur_ext[COUNT_W-1:0];
                    r_rsp.read_value  <= EMPTY_ID;
                    r_done            <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    // Every result beat is a single cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held two cycles");

    // An accepted request keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // RAM writes stay inside the stored list or append at its end.
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CW'(ram_waddr) <= r_count))
        else $error("RAM write beyond the list");

    // Count moves only together with a result beat.
    a_count_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> o_done)
        else $error("count changed without a result");

endmodule

// ===== rtl/bidst_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bidst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounded_id_set_table_core: directed corner requests, then
// fill/drain sequences and random request mixes checked against a cycle-free table tracker.
// Depends on bidst_pkg and the core RTL (bounded_id_set_table_core with its entry RAM).
module testbench;
    import bidst_pkg::*;

    localparam int SLOTS       = 64;    // CAPACITY of the instance under test
    localparam int POOL_N      = 96;    // more ids than slots, so the table can fill
    localparam int FILL_N      = 68;    // a few adds past capacity
    localparam int QUIET_LIMIT = 4000;  // cycles with no beat before the run is abandoned
    localparam int MAX_REPORTS = 30;

    // Tracks the packed id list and count, and the responses still owed by the core.
    class id_table_tracker;
        logic [ID_W-1:0] slots [SLOTS];
        int unsigned     stored;
        t_rsp            owed [$];
        int              errors;
        int              taken;
        int              adds_ok;
        int              adds_full;
        int              dels_ok;
        int              query_hits;
        int              reads_seen;
        int unsigned     peak;

        function new();
            foreach (slots[i]) slots[i] = EMPTY_ID;
            stored     = 0;
            errors     = 0;
            taken      = 0;
            adds_ok    = 0;
            adds_full  = 0;
            dels_ok    = 0;
            query_hits = 0;
            reads_seen = 0;
            peak       = 0;
        endfunction

        function bit locate(logic [ID_W-1:0] id, output int unsigned pos);
            int unsigned i;
            pos = 0;
            for (i = 0; i < stored; i++) begin
                if (slots[i] == id) begin
                    pos = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic [ID_W-1:0] pick_stored();
            return slots[$urandom_range(0, stored - 1)];
        endfunction

        // Apply one accepted request to the tracked table and queue its response.
        function void log_request(t_req r);
            logic [ID_W-1:0] id;
            int unsigned     pos;
            int unsigned     i;
            bit              hit;
            t_rsp            want;
            id              = r.item_id;
            hit             = locate(id, pos);
            want.status     = STATUS_ERR;
            want.read_value = EMPTY_ID;
            taken++;
            case (r.mode)
                MODE_ADD: begin
                    if (stored >= SLOTS) begin
                        adds_full++;
                    end else if (!hit) begin
                        slots[stored] = id;
                        stored++;
                        want.status = STATUS_OK;
                        adds_ok++;
                    end
                end
                MODE_DEL: begin
                    if (hit) begin
                        for (i = pos; i + 1 < stored; i++) slots[i] = slots[i + 1];
                        slots[stored - 1] = EMPTY_ID;
                        stored--;
                        want.status = STATUS_OK;
                        dels_ok++;
                    end
                end
                MODE_QUERY: begin
                    if (id != EMPTY_ID && hit) begin
                        want.status = STATUS_OK;
                        query_hits++;
                    end
                end
                MODE_READ: begin
                    want.read_value = slots[r.slot_index];
                    want.status     = (r.slot_index < stored) ? STATUS_OK : STATUS_ERR;
                    reads_seen++;
                end
            endcase
            want.entry_count = COUNT_W'(stored);
            if (stored > peak) peak = stored;
            owed.push_back(want);
        endfunction

        function void flag(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        endfunction

        function void match_response(t_rsp got);
            t_rsp want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: response with none owed: expected nothing, actual %h",
                             $time, got);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                flag("status", ID_W'(want.status), ID_W'(got.status));
            if (got.entry_count !== want.entry_count)
                flag("entry_count", ID_W'(want.entry_count), ID_W'(got.entry_count));
            if (got.read_value !== want.read_value)
                flag("read_value", want.read_value, got.read_value);
        endfunction
    endclass

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_req    i_req   = '0;
    logic    busy;
    logic    o_done;
    t_rsp    o_rsp;

    id_table_tracker ledger = new();
    logic [ID_W-1:0] id_pool [POOL_N];
    int              quiet_cycles = 0;

    bounded_id_set_table_core #(
        .CAPACITY (SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sample both channels on the rising edge, before the core's own updates land.
    // Log the request first: when a response and a new request share an edge, the
    // response belongs to the older request, which already sits at the queue head.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) ledger.log_request(i_req);
            if (o_done) ledger.match_response(o_rsp);
            if ((start && !busy) || o_done) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat in %0d cycles, abandoning run", $time, QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Present one request and hold it until the core takes the beat. With pause set,
    // drop start afterwards and idle for a short burst; otherwise keep start high so
    // the next request follows back to back.
    task automatic issue(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
                         logic [IDX_W-1:0] idx, bit pause);
        t_req r;
        r.mode       = m;
        r.item_id    = id;
        r.slot_index = idx;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (pause) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed response has come back. Step past the next edge
    // first so the request taken at the last edge is already logged.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.owed.size() != 0) @(posedge i_clk);
    endtask

    // One random request. bias picks the mode mix: 0 grows the table, 1 shrinks it,
    // 2 keeps it wandering. Deletes and queries mostly aim at ids that are stored.
    task automatic random_item(int bias, bit idle_ok);
        int              r;
        int              add_cut;
        int              del_cut;
        int              qry_cut;
        logic [MODE_W-1:0] m;
        logic [ID_W-1:0]   id;
        logic [IDX_W-1:0]  idx;
        case (bias)
            0:       begin add_cut = 60; del_cut = 75; qry_cut = 90; end
            1:       begin add_cut = 20; del_cut = 65; qry_cut = 85; end
            default: begin add_cut = 35; del_cut = 60; qry_cut = 85; end
        endcase
        r = $urandom_range(0, 99);
        if (r < add_cut)      m = MODE_ADD;
        else if (r < del_cut) m = MODE_DEL;
        else if (r < qry_cut) m = MODE_QUERY;
        else                  m = MODE_READ;
        r = $urandom_range(0, 99);
        if (m != MODE_ADD && ledger.stored > 0 && r < 55) id = ledger.pick_stored();
        else if (r < 88) id = id_pool[$urandom_range(0, POOL_N - 1)];
        else id = $urandom();
        if (ledger.stored > 0 && $urandom_range(0, 1) == 1)
            idx = IDX_W'($urandom_range(0, ledger.stored - 1));
        else
            idx = IDX_W'($urandom_range(0, SLOTS - 1));
        issue(m, id, idx, idle_ok && ($urandom_range(0, 3) == 0));
    endtask

    initial begin
        int order [FILL_N];
        int k;
        int j;
        int tmp;
        int seg;
        int seg_bias;
        bit seg_idle;

        // Build the id pool: the field extremes and the empty marker, then random ids.
        foreach (id_pool[n]) id_pool[n] = $urandom();
        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7FFF_FFFF;
        id_pool[2] = EMPTY_ID;
        id_pool[3] = 32'h0000_0000;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners on an empty table.
        issue(MODE_QUERY, EMPTY_ID,     6'd0,  1'b0);  // marker query, table empty
        issue(MODE_READ,  32'h0,        6'd0,  1'b0);  // read below capacity, nothing stored
        issue(MODE_READ,  EMPTY_ID,     6'd63, 1'b0);  // last slot
        issue(MODE_DEL,   32'h1234_5678, 6'd0, 1'b0);  // delete on an empty table
        // Store the field extremes and the marker itself as an ordinary id.
        issue(MODE_ADD,   32'h8000_0000, 6'h3F, 1'b1);
        issue(MODE_ADD,   32'h7FFF_FFFF, 6'd0, 1'b0);
        issue(MODE_ADD,   EMPTY_ID,     6'd0,  1'b0);
        issue(MODE_ADD,   32'h0,        6'd0,  1'b1);
        issue(MODE_ADD,   32'h7FFF_FFFF, 6'd0, 1'b0);  // duplicate, refused
        issue(MODE_QUERY, EMPTY_ID,     6'd0,  1'b0);  // marker reads absent though stored
        issue(MODE_QUERY, 32'h8000_0000, 6'd0, 1'b0);  // hit on first slot
        issue(MODE_QUERY, 32'h0,        6'd0,  1'b0);  // hit on last slot
        issue(MODE_QUERY, 32'h5555_AAAA, 6'd0, 1'b0);  // miss
        issue(MODE_READ,  32'h0,        6'd2,  1'b0);  // stored marker, inside count
        issue(MODE_READ,  32'h0,        6'd3,  1'b1);
        issue(MODE_READ,  32'h0,        6'd4,  1'b0);  // just past the count
        issue(MODE_DEL,   32'h8000_0000, 6'd0, 1'b0);  // first entry, shift all down
        issue(MODE_DEL,   32'h8000_0000, 6'd0, 1'b0);  // now absent
        issue(MODE_READ,  32'h0,        6'd3,  1'b0);  // freed slot reports the marker
        issue(MODE_READ,  32'h0,        6'd0,  1'b0);
        issue(MODE_DEL,   EMPTY_ID,     6'd0,  1'b1);  // marker deletes like any id
        issue(MODE_DEL,   32'h0,        6'd0,  1'b0);  // last entry, no shift
        issue(MODE_DEL,   32'h7FFF_FFFF, 6'd0, 1'b0);  // back to empty
        issue(MODE_READ,  32'h0,        6'd0,  1'b0);
        drain();

        // Fill past capacity so the last adds bounce off a full table.
        for (k = 0; k < FILL_N; k++)
            issue(MODE_ADD, id_pool[k], IDX_W'($urandom_range(0, SLOTS - 1)),
                  $urandom_range(0, 4) == 0);
        issue(MODE_READ,  32'h0,        6'd63, 1'b0);
        issue(MODE_QUERY, id_pool[SLOTS - 1], 6'd0, 1'b1);
        issue(MODE_ADD,   $urandom(),   6'd0,  1'b0);
        drain();

        // Empty it again in shuffled order, so deletes hit entries at varied positions.
        foreach (order[n]) order[n] = n;
        for (k = FILL_N - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < FILL_N; k++)
            issue(MODE_DEL, id_pool[order[k]], IDX_W'($urandom_range(0, SLOTS - 1)),
                  $urandom_range(0, 4) == 0);

        // Random segments with a drifting mode mix; the last two run without idling.
        for (seg = 0; seg < 11; seg++) begin
            seg_bias = $urandom_range(0, 2);
            seg_idle = (seg < 9) && ($urandom_range(0, 3) != 0);
            repeat (105) random_item(seg_bias, seg_idle);
            if ((seg < 9) && ($urandom_range(0, 2) == 0)) drain();
        end

        drain();
        repeat (SLOTS + 8) @(posedge i_clk);

        $display("Covered %0d requests: %0d adds stored, %0d refused on a full table, %0d deletes,",
                 ledger.taken, ledger.adds_ok, ledger.adds_full, ledger.dels_ok);
        $display("%0d query hits, %0d reads; table peaked at %0d of %0d slots.",
                 ledger.query_hits, ledger.reads_seen, ledger.peak, SLOTS);
        if (ledger.errors == 0 && ledger.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bidst_pkg.sv
rtl/bidst_ram.sv
rtl/bounded_id_set_table_core.sv
dv/testbench.sv
